### src/u16u8_pkg.sv
package u16u8_pkg;

    // Result buffer: one item yields at most two code points, six bytes.
    localparam int C_MAX_RES = 6;
    localparam int C_CNT_W   = $clog2(C_MAX_RES + 1);

    // Code unit prefixes of the surrogate ranges (top six bits).
    localparam logic [5:0] C_HIGH_PFX = 6'b110110;
    localparam logic [5:0] C_LOW_PFX  = 6'b110111;

    // Code points and range limits.
    localparam logic [20:0] C_CP_REPL  = 21'h00FFFD;
    localparam logic [20:0] C_CP_SUPP  = 21'h010000;
    localparam logic [20:0] C_LIM_1B   = 21'h000080;
    localparam logic [20:0] C_LIM_2B   = 21'h000800;
    localparam logic [20:0] C_LIM_3B   = 21'h010000;

    // Lead and continuation marks of UTF-8.
    localparam logic [7:0] C_LEAD2 = 8'hC0;
    localparam logic [7:0] C_LEAD3 = 8'hE0;
    localparam logic [7:0] C_LEAD4 = 8'hF0;
    localparam logic [7:0] C_CONT  = 8'h80;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      len;
    } t_enc;

    // UTF-8 encoding of one code point below U+110000.
    function automatic t_enc f_encode(input logic [20:0] cp);
        t_enc e;
        e.bytes = '0;
        if (cp < C_LIM_1B) begin
            e.len      = 3'd1;
            e.bytes[0] = {1'b0, cp[6:0]};
        end else if (cp < C_LIM_2B) begin
            e.len      = 3'd2;
            e.bytes[0] = C_LEAD2 | {3'b000, cp[10:6]};
            e.bytes[1] = C_CONT | {2'b00, cp[5:0]};
        end else if (cp < C_LIM_3B) begin
            e.len      = 3'd3;
            e.bytes[0] = C_LEAD3 | {4'b0000, cp[15:12]};
            e.bytes[1] = C_CONT | {2'b00, cp[11:6]};
            e.bytes[2] = C_CONT | {2'b00, cp[5:0]};
        end else begin
            e.len      = 3'd4;
            e.bytes[0] = C_LEAD4 | {5'b00000, cp[20:18]};
            e.bytes[1] = C_CONT | {2'b00, cp[17:12]};
            e.bytes[2] = C_CONT | {2'b00, cp[11:6]};
            e.bytes[3] = C_CONT | {2'b00, cp[5:0]};
        end
        return e;
    endfunction

endpackage

### src/u16u8_ifs.sv
// Input channel: one raw UTF-16 byte per beat.
interface u16u8_in_if import u16u8_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte data_byte;
    logic  end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

// Output channel: one UTF-8 byte per beat.
interface u16u8_out_if import u16u8_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte utf8_byte;
    logic  last_of_run;

    modport source (output valid, output utf8_byte, output last_of_run, input ready);
    modport sink   (input valid, input utf8_byte, input last_of_run, output ready);
endinterface

### src/utf16_to_utf8_transcoder.sv
// Results of an input beat appear on the output in the cycle after it is accepted.
// A beat that completes no code point leaves the buffer empty and the input ready; one
// that does yields 1 to 6 UTF-8 bytes, sent one per cycle while o_out.ready is high.
// The next input beat is taken in the same cycle as the last output byte of the previous one.
// Reset (synchronous, active low) clears the decode state, the buffer count and index, and big_endian.
module utf16_to_utf8_transcoder
    import u16u8_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic         i_cfg_wr_data,
    u16u8_in_if.sink     i_in,
    u16u8_out_if.source  o_out
);

    // Configuration and decode state.
    logic               r_big_endian;
    logic               r_byte_held;
    t_byte              r_held_byte;
    logic               r_sur_held;
    logic [9:0]         r_high_bits;

    // Result buffer.
    t_byte              r_buf [C_MAX_RES];
    logic [C_CNT_W-1:0] r_cnt;
    logic [C_CNT_W-1:0] r_idx;

    logic               in_fire;
    logic               out_fire;
    logic               out_last;

    logic [15:0]        unit;
    logic               is_high;
    logic               is_low;
    logic               pair_sur;
    logic               emit_unit;
    logic               n_sur_held;
    logic               flush_repl;
    logic [20:0]        supp_cp;
    logic [20:0]        cp_a;
    logic [20:0]        cp_b;
    logic               a_v;
    logic               b_v;
    t_enc               enc_a;
    t_enc               enc_b;
    logic [C_CNT_W-1:0] n_cnt;
    t_byte              n_buf [C_MAX_RES];

    // Handshakes; the buffer frees up on its last beat.
    assign out_last        = (r_idx == r_cnt - C_CNT_W'(1));
    assign o_out.valid     = (r_cnt != '0);
    assign o_out.utf8_byte = r_buf[r_idx];
    assign o_out.last_of_run = out_last;
    assign out_fire        = o_out.valid && o_out.ready;
    assign i_in.ready      = (r_cnt == '0) || (out_fire && out_last);
    assign in_fire         = i_in.valid && i_in.ready;

    // Form the code unit and classify it.
    assign unit    = r_big_endian ? {r_held_byte, i_in.data_byte}
                                  : {i_in.data_byte, r_held_byte};
    assign is_high = (unit[15:10] == C_HIGH_PFX);
    assign is_low  = (unit[15:10] == C_LOW_PFX);
    assign supp_cp = C_CP_SUPP + {1'b0, r_high_bits, unit[9:0]};

    // Which code points this beat yields: at most two, in order.
    assign pair_sur   = r_byte_held && r_sur_held;
    assign emit_unit  = r_byte_held && !is_high && !(r_sur_held && is_low);
    assign n_sur_held = r_byte_held ? (is_high && !(r_sur_held && is_low)) : r_sur_held;
    assign flush_repl = i_in.end_of_stream && n_sur_held;

    always_comb begin
        a_v  = pair_sur || emit_unit || flush_repl;
        b_v  = pair_sur && (emit_unit || flush_repl);
        cp_b = emit_unit ? {5'b00000, unit} : C_CP_REPL;
        if (pair_sur) begin
            cp_a = is_low ? supp_cp : C_CP_REPL;
        end else begin
            cp_a = cp_b;
        end
    end

    assign enc_a = f_encode(cp_a);
    assign enc_b = f_encode(cp_b);
    assign n_cnt = (a_v ? C_CNT_W'(enc_a.len) : '0) + (b_v ? C_CNT_W'(enc_b.len) : '0);

    // Lay out the bytes of both code points back to back.
    always_comb begin
        logic [2:0] pos;
        for (int i = 0; i < C_MAX_RES; i++) begin
            pos = 3'(i);
            if (pos < enc_a.len) begin
                n_buf[i] = enc_a.bytes[pos[1:0]];
            end else begin
                n_buf[i] = enc_b.bytes[2'(pos - enc_a.len)];
            end
        end
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_big_endian <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_big_endian <= i_cfg_wr_data;
        end
    end

    // Decode state update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_held <= 1'b0;
            r_held_byte <= '0;
            r_sur_held  <= 1'b0;
            r_high_bits <= '0;
        end else if (in_fire) begin
            if (i_in.end_of_stream) begin
                r_byte_held <= 1'b0;
                r_held_byte <= '0;
                r_sur_held  <= 1'b0;
                r_high_bits <= '0;
            end else if (!r_byte_held) begin
                r_byte_held <= 1'b1;
                r_held_byte <= i_in.data_byte;
            end else begin
                r_byte_held <= 1'b0;
                r_held_byte <= '0;
                r_sur_held  <= n_sur_held;
                r_high_bits <= n_sur_held ? unit[9:0] : '0;
            end
        end
    end

    // Result buffer control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (in_fire) begin
            r_cnt <= n_cnt;
            r_idx <= '0;
        end else if (out_fire) begin
            if (out_last) begin
                r_cnt <= '0;
                r_idx <= '0;
            end else begin
                r_idx <= r_idx + C_CNT_W'(1);
            end
        end
    end

    // Result buffer payload.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            for (int i = 0; i < C_MAX_RES; i++) begin
                r_buf[i] <= n_buf[i];
            end
        end
    end

`ifndef SYNTH
    // A valid output always points inside the filled part of the buffer.
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (r_idx < r_cnt))
        else $error("output index beyond buffer fill");

    // A new input beat is never taken while unsent bytes remain.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && i_in.ready) |-> (o_out.ready && out_last))
        else $error("input accepted over pending output");

    // End of stream leaves no held byte and no held surrogate.
    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in.end_of_stream) |=> (!r_byte_held && !r_sur_held))
        else $error("state not cleared after end of stream");
`endif

endmodule
